>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, clocked on clk, held off during reset.
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, held off during reset.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/sgm_pkg.sv
`default_nettype none
package sgm_pkg;
    localparam int MAX_COLS_DEF   = 1024;
    localparam int COORD_BITS_DEF = 24;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int NUM_COLS_BITS = 11;
    localparam int NUM_ROWS_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS = 1'b1;

    localparam logic [NUM_COLS_BITS-1:0] NUM_COLS_RST = 11'd1024;
    localparam logic [NUM_ROWS_BITS-1:0] NUM_ROWS_RST = 16'd1024;

    typedef struct packed {
        logic eta;
        logic xi;
        logic quad;
    } flags_t;
endpackage
`default_nettype wire

>>> rtl/core/sgm_front.sv
`default_nettype none
module sgm_front #(
    parameter int MAX_COLS   = sgm_pkg::MAX_COLS_DEF,
    parameter int COORD_BITS = sgm_pkg::COORD_BITS_DEF,
    localparam int CB    = COORD_BITS,
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int REC_W = 8 * CB + 3
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [sgm_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
    input  wire logic [sgm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [CB-1:0]                 node_x,
    input  wire logic signed [CB-1:0]                 node_y,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output logic [REC_W-1:0]                          push_data
);
    localparam logic F_IDLE = 1'b0;
    localparam logic F_PUSH = 1'b1;

    logic state_reg;
    logic [CB-1:0] cx_reg, cy_reg, rd_x_reg, rd_y_reg;
    logic [CB-1:0] ul_x_reg, ul_y_reg, left_x_reg, left_y_reg;
    logic [CW-1:0] col_reg;
    logic [sgm_pkg::NUM_ROWS_BITS-1:0] row_reg;
    logic [sgm_pkg::NUM_COLS_BITS-1:0] ncols_reg;
    logic [sgm_pkg::NUM_ROWS_BITS-1:0] nrows_reg;

    logic [CB-1:0] mem_x [MAX_COLS];
    logic [CB-1:0] mem_y [MAX_COLS];

    sgm_pkg::flags_t flags;
    logic in_fire, push_fire, wrap_col, wrap_row;

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign in_fire    = in_valid && in_ready;
    assign push_fire  = push_valid && push_ready;

    assign flags.eta  = (row_reg != '0);
    assign flags.xi   = (col_reg != '0);
    assign flags.quad = flags.eta && flags.xi;

    assign wrap_col = (32'(col_reg) + 32'd1 >= 32'(ncols_reg)) ||
                      (32'(col_reg) + 32'd1 >= 32'(MAX_COLS));
    assign wrap_row = (32'(row_reg) + 32'd1 >= 32'(nrows_reg));

    assign push_data = {flags, cx_reg, cy_reg, rd_x_reg, rd_y_reg,
                        ul_x_reg, ul_y_reg, left_x_reg, left_y_reg};

    // Row line: read ahead at the current column, write back on push.
    always_ff @(posedge clk)
    begin
        rd_x_reg <= mem_x[col_reg];
        rd_y_reg <= mem_y[col_reg];
        if (push_fire)
        begin
            mem_x[col_reg] <= cx_reg;
            mem_y[col_reg] <= cy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cx_reg <= node_x;
            cy_reg <= node_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            ul_x_reg   <= '0;
            ul_y_reg   <= '0;
            left_x_reg <= '0;
            left_y_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            ncols_reg  <= sgm_pkg::NUM_COLS_RST;
            nrows_reg  <= sgm_pkg::NUM_ROWS_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    sgm_pkg::REG_NUM_COLS:
                        ncols_reg <= cfg_data[sgm_pkg::NUM_COLS_BITS-1:0];
                    sgm_pkg::REG_NUM_ROWS:
                        nrows_reg <= cfg_data[sgm_pkg::NUM_ROWS_BITS-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                F_IDLE:
                begin
                    if (in_fire)
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_fire)
                    begin
                        state_reg  <= F_IDLE;
                        ul_x_reg   <= rd_x_reg;
                        ul_y_reg   <= rd_y_reg;
                        left_x_reg <= cx_reg;
                        left_y_reg <= cy_reg;
                        if (wrap_col)
                        begin
                            col_reg <= '0;
                            row_reg <= wrap_row ? '0 : row_reg + 1'b1;
                        end
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/sgm_fifo.sv
`default_nettype none
module sgm_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic wr_fire, rd_fire;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_fire)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_fire)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_fire && !rd_fire)
                count_reg <= count_reg + 2'd1;
            else if (rd_fire && !wr_fire)
                count_reg <= count_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/sgm_isqrt.sv
`default_nettype none
module sgm_isqrt #(
    parameter int RW = 50,
    localparam int N  = RW / 2,
    localparam int NW = $clog2(N + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [RW-1:0] radicand,
    output logic               busy,
    output logic [N-1:0]       root
);
    logic [RW-1:0] rad_reg;
    logic [N+1:0]  rem_reg;
    logic [N-1:0]  root_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic [N+1:0]  rem_sh, trial;

    assign rem_sh = {rem_reg[N-1:0], rad_reg[RW-1:RW-2]};
    assign trial  = {root_reg, 2'b01};
    assign busy   = busy_reg;
    assign root   = root_reg;

    // One result bit per cycle, two radicand bits in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= NW'(N);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
                busy_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/sgm_back.sv
`default_nettype none
module sgm_back #(
    parameter int COORD_BITS = sgm_pkg::COORD_BITS_DEF,
    localparam int CB    = COORD_BITS,
    localparam int NB    = CB + 1,
    localparam int PW    = 2 * NB,
    localparam int AW    = 2 * CB + 4,
    localparam int ACCW  = AW + 2,
    localparam int REC_W = 8 * CB + 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pop_valid,
    output logic                        pop_ready,
    input  wire logic [REC_W-1:0]       pop_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        eta_face_valid,
    output logic                        xi_face_valid,
    output logic                        cell_valid,
    output logic signed [NB-1:0]        eta_normal_x,
    output logic signed [NB-1:0]        eta_normal_y,
    output logic signed [NB-1:0]        xi_normal_x,
    output logic signed [NB-1:0]        xi_normal_y,
    output logic signed [AW-1:0]        cell_area,
    output logic signed [CB-1:0]        center_x,
    output logic signed [CB-1:0]        center_y,
    output logic [NB-1:0]               eta_face_length,
    output logic [NB-1:0]               xi_face_length
);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIFF = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_SQST = 3'd3;
    localparam logic [2:0] B_SQRT = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    localparam logic [3:0] ST_AREA_A = 4'd0;
    localparam logic [3:0] ST_AREA_B = 4'd1;
    localparam logic [3:0] ST_AREA_C = 4'd2;
    localparam logic [3:0] ST_AREA_D = 4'd3;
    localparam logic [3:0] ST_ETA_X  = 4'd4;
    localparam logic [3:0] ST_ETA_Y  = 4'd5;
    localparam logic [3:0] ST_XI_X   = 4'd6;
    localparam logic [3:0] ST_XI_Y   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [2:0] state_reg;
    logic [3:0] step_reg;
    logic [REC_W-1:0] rec_reg;

    sgm_pkg::flags_t flags;
    logic signed [CB-1:0] cx, cy, ux, uy, ulx, uly, lx, ly;

    logic signed [NB-1:0] ex_reg, ey_reg, xx_reg, xy_reg;
    logic signed [NB-1:0] e2x_reg, e2y_reg, x2x_reg, x2y_reg;
    logic signed [NB-1:0] enx_reg, eny_reg, xnx_reg, xny_reg;
    logic signed [CB-1:0] ctx_reg, cty_reg;
    logic signed [NB-1:0] op_a, op_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [ACCW-1:0] area_acc_reg, prod_ext;
    logic [PW-1:0] len_e_reg, len_x_reg;
    logic [3:0] prev_step;
    logic signed [CB+1:0] sum_x, sum_y;
    logic sq_start, busy_e, busy_x;
    logic [NB-1:0] root_e, root_x;
    logic load_out;

    assign {flags, cx, cy, ux, uy, ulx, uly, lx, ly} = rec_reg;

    assign pop_ready = (state_reg == B_IDLE);
    assign sq_start  = (state_reg == B_SQST);
    assign load_out  = (state_reg == B_OUT) && (!out_valid || out_ready);
    assign prev_step = step_reg - 4'd1;
    assign prod_ext  = ACCW'(prod_reg);

    assign sum_x = (CB+2)'(ulx) + (CB+2)'(lx) + (CB+2)'(ux) + (CB+2)'(cx);
    assign sum_y = (CB+2)'(uly) + (CB+2)'(ly) + (CB+2)'(uy) + (CB+2)'(cy);

    always_comb
    begin
        case (step_reg)
            ST_AREA_A: begin op_a = ex_reg;  op_b = xy_reg;  end
            ST_AREA_B: begin op_a = xx_reg;  op_b = ey_reg;  end
            ST_AREA_C: begin op_a = e2x_reg; op_b = x2y_reg; end
            ST_AREA_D: begin op_a = x2x_reg; op_b = e2y_reg; end
            ST_ETA_X:  begin op_a = ex_reg;  op_b = ex_reg;  end
            ST_ETA_Y:  begin op_a = ey_reg;  op_b = ey_reg;  end
            ST_XI_X:   begin op_a = xx_reg;  op_b = xx_reg;  end
            ST_XI_Y:   begin op_a = xy_reg;  op_b = xy_reg;  end
            default:   begin op_a = '0;      op_b = '0;      end
        endcase
    end

    sgm_isqrt #(.RW(PW)) u_sqrt_eta (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(len_e_reg),
        .busy(busy_e), .root(root_e)
    );

    sgm_isqrt #(.RW(PW)) u_sqrt_xi (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(len_x_reg),
        .busy(busy_x), .root(root_x)
    );

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
            rec_reg <= pop_data;
        if (state_reg == B_DIFF)
        begin
            ex_reg  <= NB'(lx) - NB'(ulx);
            ey_reg  <= NB'(ly) - NB'(uly);
            xx_reg  <= NB'(ux) - NB'(ulx);
            xy_reg  <= NB'(uy) - NB'(uly);
            e2x_reg <= NB'(cx) - NB'(ux);
            e2y_reg <= NB'(cy) - NB'(uy);
            x2x_reg <= NB'(cx) - NB'(lx);
            x2y_reg <= NB'(cy) - NB'(ly);
            enx_reg <= NB'(uy) - NB'(cy);
            eny_reg <= NB'(cx) - NB'(ux);
            xnx_reg <= NB'(cy) - NB'(ly);
            xny_reg <= NB'(lx) - NB'(cx);
            ctx_reg <= sum_x[CB+1:2];
            cty_reg <= sum_y[CB+1:2];
            area_acc_reg <= '0;
            len_e_reg    <= '0;
            len_x_reg    <= '0;
        end
        if (state_reg == B_MUL)
        begin
            prod_reg <= op_a * op_b;
            if (step_reg != ST_AREA_A)
            begin
                case (prev_step)
                    ST_AREA_A, ST_AREA_C: area_acc_reg <= area_acc_reg + prod_ext;
                    ST_AREA_B, ST_AREA_D: area_acc_reg <= area_acc_reg - prod_ext;
                    ST_ETA_X, ST_ETA_Y:   len_e_reg <= len_e_reg + PW'(prod_reg);
                    ST_XI_X, ST_XI_Y:     len_x_reg <= len_x_reg + PW'(prod_reg);
                    default: ;
                endcase
            end
        end
        if (load_out)
        begin
            eta_face_valid  <= flags.eta;
            xi_face_valid   <= flags.xi;
            cell_valid      <= flags.quad;
            eta_normal_x    <= flags.eta  ? enx_reg : '0;
            eta_normal_y    <= flags.eta  ? eny_reg : '0;
            xi_normal_x     <= flags.xi   ? xnx_reg : '0;
            xi_normal_y     <= flags.xi   ? xny_reg : '0;
            cell_area       <= flags.quad ? area_acc_reg[AW:1] : '0;
            center_x        <= flags.quad ? ctx_reg : '0;
            center_y        <= flags.quad ? cty_reg : '0;
            eta_face_length <= flags.quad ? root_e : '0;
            xi_face_length  <= flags.quad ? root_x : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= ST_AREA_A;
            out_valid <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                B_IDLE:
                    if (pop_valid)
                        state_reg <= B_DIFF;
                B_DIFF:
                begin
                    step_reg  <= ST_AREA_A;
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    if (step_reg == ST_DONE)
                        state_reg <= B_SQST;
                    else
                        step_reg <= step_reg + 4'd1;
                end
                B_SQST: state_reg <= B_SQRT;
                B_SQRT:
                    if (!busy_e && !busy_x)
                        state_reg <= B_OUT;
                B_OUT:
                    if (load_out)
                        state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/structured_grid_metrics_2d_core.sv
// Path: front, queue, back end, then the output register; output stalls hold beats back.
// Back end: takes no new record until the last is in the output register; runs the
//   shared 25x25 multiplier, then two 25-step bit-serial square roots in parallel.
// Reset: rst_n is asynchronous, active low; clears counters, neighbor nodes, queue,
//   and sets num_cols and num_rows to 1024. The row line is not cleared.
`default_nettype none
module structured_grid_metrics_2d_core #(
    parameter int MAX_COLS   = sgm_pkg::MAX_COLS_DEF,
    parameter int COORD_BITS = sgm_pkg::COORD_BITS_DEF,
    localparam int CB    = COORD_BITS,
    localparam int NB    = CB + 1,
    localparam int AW    = 2 * CB + 4,
    localparam int REC_W = 8 * CB + 3
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [sgm_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [sgm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [CB-1:0]              node_x,
    input  wire logic signed [CB-1:0]              node_y,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   eta_face_valid,
    output logic                                   xi_face_valid,
    output logic                                   cell_valid,
    output logic signed [NB-1:0]                   eta_normal_x,
    output logic signed [NB-1:0]                   eta_normal_y,
    output logic signed [NB-1:0]                   xi_normal_x,
    output logic signed [NB-1:0]                   xi_normal_y,
    output logic signed [AW-1:0]                   cell_area,
    output logic signed [CB-1:0]                   center_x,
    output logic signed [CB-1:0]                   center_y,
    output logic [NB-1:0]                          eta_face_length,
    output logic [NB-1:0]                          xi_face_length
);
    // Front -> queue -> back. The front reads the row line, tracks row and column,
    // and packs each node with its three neighbors and valid flags into one record.
    logic             push_valid, push_ready, pop_valid, pop_ready;
    logic [REC_W-1:0] push_data, pop_data;

    sgm_front #(.MAX_COLS(MAX_COLS), .COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .node_x(node_x), .node_y(node_y),
        .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
    );

    // Two-entry queue: hold records while the back end grinds.
    sgm_fifo #(.WIDTH(REC_W)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
        .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_data)
    );

    // Back end: differences, area and squared lengths on one multiplier,
    // then two square roots in parallel, then the output register.
    sgm_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .eta_face_valid(eta_face_valid), .xi_face_valid(xi_face_valid),
        .cell_valid(cell_valid),
        .eta_normal_x(eta_normal_x), .eta_normal_y(eta_normal_y),
        .xi_normal_x(xi_normal_x), .xi_normal_y(xi_normal_y),
        .cell_area(cell_area), .center_x(center_x), .center_y(center_y),
        .eta_face_length(eta_face_length), .xi_face_length(xi_face_length)
    );
endmodule
`default_nettype wire

>>> rtl/core/sgm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sgm_checker #(
    parameter int CB = sgm_pkg::COORD_BITS_DEF,
    localparam int NB = CB + 1,
    localparam int AW = 2 * CB + 4
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic                 eta_face_valid,
    input wire logic                 xi_face_valid,
    input wire logic                 cell_valid,
    input wire logic signed [NB-1:0] eta_normal_x,
    input wire logic signed [NB-1:0] eta_normal_y,
    input wire logic signed [AW-1:0] cell_area,
    input wire logic [NB-1:0]        eta_face_length
);
    `AST_SAME(a_cell_needs_faces, out_valid && cell_valid, eta_face_valid && xi_face_valid)
    `AST_SAME(a_eta_zero, out_valid && !eta_face_valid, eta_normal_x == 0 && eta_normal_y == 0)
    `AST_SAME(a_cell_zero, out_valid && !cell_valid, cell_area == 0 && eta_face_length == 0)
    `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_area))
endmodule

bind structured_grid_metrics_2d_core sgm_checker #(.CB(COORD_BITS)) u_sgm_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .eta_face_valid(eta_face_valid), .xi_face_valid(xi_face_valid),
    .cell_valid(cell_valid), .eta_normal_x(eta_normal_x), .eta_normal_y(eta_normal_y),
    .cell_area(cell_area), .eta_face_length(eta_face_length)
);
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;
    localparam int CB = 24;
    localparam int NB = CB + 1;
    localparam int AW = 2 * CB + 4;
    localparam int LINE_DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 200;
    localparam int WIDE_TAIL = 32;

    // One grid-metrics result as the block presents it.
    typedef struct packed {
        logic                 eta_v;
        logic                 xi_v;
        logic                 cell_v;
        logic signed [NB-1:0] eta_nx;
        logic signed [NB-1:0] eta_ny;
        logic signed [NB-1:0] xi_nx;
        logic signed [NB-1:0] xi_ny;
        logic signed [AW-1:0] area;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic [NB-1:0]        eta_len;
        logic [NB-1:0]        xi_len;
    } metrics_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sgm_pkg::CFG_IDX_BITS-1:0] cfg_addr;
    logic [sgm_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [CB-1:0] node_x;
    logic signed [CB-1:0] node_y;
    logic out_valid;
    logic out_ready;
    metrics_t dut_res;

    structured_grid_metrics_2d_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .node_x          (node_x),
        .node_y          (node_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .eta_face_valid  (dut_res.eta_v),
        .xi_face_valid   (dut_res.xi_v),
        .cell_valid      (dut_res.cell_v),
        .eta_normal_x    (dut_res.eta_nx),
        .eta_normal_y    (dut_res.eta_ny),
        .xi_normal_x     (dut_res.xi_nx),
        .xi_normal_y     (dut_res.xi_ny),
        .cell_area       (dut_res.area),
        .center_x        (dut_res.cx),
        .center_y        (dut_res.cy),
        .eta_face_length (dut_res.eta_len),
        .xi_face_length  (dut_res.xi_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Grid model: line of the previous row, the two latest neighbors, and
    // the row/column position. Line entries are only read after the
    // current grid has written them, so no reset value matters.
    // ------------------------------------------------------------------
    logic signed [CB-1:0] line_x [LINE_DEPTH];
    logic signed [CB-1:0] line_y [LINE_DEPTH];
    logic signed [CB-1:0] ul_x, ul_y, left_x, left_y;
    int unsigned row_pos, col_pos;
    int unsigned cols_cfg, rows_cfg;

    metrics_t metrics_due[$];
    int mismatch_count;
    int accept_count;
    int results_seen;
    bit long_hold;

    function automatic logic [NB-1:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[NB-1:0];
    endfunction

    function automatic logic [NB-1:0] edge_len(input longint dx, input longint dy);
        return isqrt(64'(dx * dx + dy * dy));
    endfunction

    // Compute the metrics for one node and advance the grid position.
    task automatic predict_metrics(input logic signed [CB-1:0] nx,
                                   input logic signed [CB-1:0] ny);
        metrics_t r;
        int unsigned c;
        longint x, y, ux, uy, lx, ly, qx, qy;
        longint ex, ey, xx, xy, e2x, e2y, x2x, x2y, sum;
        c = (col_pos >= LINE_DEPTH) ? 0 : col_pos;
        x = nx; y = ny;
        ux = line_x[c]; uy = line_y[c];
        lx = left_x; ly = left_y;
        qx = ul_x; qy = ul_y;
        r = '0;
        r.eta_v = (row_pos >= 1);
        r.xi_v = (c >= 1);
        r.cell_v = r.eta_v && r.xi_v;
        if (r.eta_v)
        begin
            r.eta_nx = NB'(uy - y);
            r.eta_ny = NB'(x - ux);
        end
        if (r.xi_v)
        begin
            r.xi_nx = NB'(y - ly);
            r.xi_ny = NB'(lx - x);
        end
        if (r.cell_v)
        begin
            ex = lx - qx; ey = ly - qy;
            xx = ux - qx; xy = uy - qy;
            e2x = x - ux; e2y = y - uy;
            x2x = x - lx; x2y = y - ly;
            sum = ex * xy - xx * ey + e2x * x2y - x2x * e2y;
            r.area = AW'(sum >>> 1);
            r.cx = CB'((qx + lx + ux + x) >>> 2);
            r.cy = CB'((qy + ly + uy + y) >>> 2);
            r.eta_len = edge_len(ex, ey);
            r.xi_len = edge_len(xx, xy);
        end
        metrics_due.push_back(r);

        ul_x = line_x[c]; ul_y = line_y[c];
        line_x[c] = nx; line_y[c] = ny;
        left_x = nx; left_y = ny;
        if (c + 1 >= cols_cfg || c + 1 >= LINE_DEPTH)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= rows_cfg) ? 0 : ((row_pos + 1) & 16'hFFFF);
        end
        else
            col_pos = c + 1;
    endtask

    // ------------------------------------------------------------------
    // Register writes: only with the block idle.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [sgm_pkg::CFG_IDX_BITS-1:0] idx,
                             input int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= sgm_pkg::CFG_DATA_BITS'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sgm_pkg::REG_NUM_COLS)
            cols_cfg = val & 16'h07FF;
        else
            rows_cfg = val & 16'hFFFF;
    endtask

    // Wait until all results are back, then let the pipeline settle.
    task automatic drain_block();
        while (metrics_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Start a fresh grid with new dimensions. The position model restarts
    // only where the block also wraps, so each grid is sent whole.
    task automatic set_grid(input int unsigned cols, input int unsigned rows);
        drain_block();
        write_reg(sgm_pkg::REG_NUM_COLS, cols);
        write_reg(sgm_pkg::REG_NUM_ROWS, rows);
    endtask

    // Sender burst state: gaps of random length between bursts.
    int burst_left;
    bit use_gaps;

    // Send one node beat; valid stays high across back-to-back beats.
    task automatic send_node(input logic signed [CB-1:0] nx, input logic signed [CB-1:0] ny);
        int gap;
        if (use_gaps && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        node_x <= nx;
        node_y <= ny;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_metrics(nx, ny);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and wait on the clock so the next beat starts clean.
    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [CB-1:0] any_coord();
        return CB'($urandom);
    endfunction

    // Mostly smooth grids with small jitter, some full-range noise.
    function automatic logic signed [CB-1:0] grid_coord(input int base, input int step_sz);
        if ($urandom_range(0, 9) == 0)
            return any_coord();
        return CB'(base + step_sz + $signed($urandom_range(0, 512)) - 256);
    endfunction

    // Send a whole grid of rows x cols nodes.
    task automatic send_grid(input int unsigned cols, input int unsigned rows,
                             input int step_sz);
        int x0;
        int y0;
        x0 = $signed($urandom_range(0, 2000000)) - 1000000;
        y0 = $signed($urandom_range(0, 2000000)) - 1000000;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_node(grid_coord(x0 + c * step_sz, 0), grid_coord(y0 + r * step_sz, 0));
        idle_input();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes on a 3x3 grid: full-scale corners and every bit flip.
    task automatic test_extremes();
        logic signed [CB-1:0] mx;
        logic signed [CB-1:0] mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        set_grid(3, 3);
        send_node(mn, mn);
        send_node(mx, mn);
        send_node(mn, mx);
        send_node(mx, mx);
        send_node(mn, mn);
        send_node(mx, mx);
        send_node(mn, mx);
        send_node(mx, mn);
        send_node(0, 0);
        send_node('1, '1);
        send_node(CB'(24'h555555), CB'(24'hAAAAAA));
        send_node(CB'(24'hAAAAAA), CB'(24'h555555));
        send_node(0, 0);
        send_node(mx, mx);
        send_node(mn, mn);
        send_node(CB'(1), CB'(-1));
        send_node(CB'(-1), CB'(1));
        send_node(mx, 0);
        idle_input();
    endtask

    // Smallest grid with a whole cell, each row two nodes, so rows and wraps come quickly.
    task automatic test_min_grid();
        set_grid(2, 2);
        send_grid(2, 2, 4096);
        send_grid(2, 2, -4096);
    endtask

    // Short rows and short grids: degenerate counts keep col or row at zero.
    task automatic test_degenerate();
        set_grid(1, 5);
        send_grid(1, 5, 4096);
        set_grid(0, 3);
        send_grid(1, 3, 4096);
        set_grid(4, 1);
        send_grid(4, 3, 4096);
        set_grid(3, 0);
        send_grid(3, 2, 4096);
    endtask

    // Full-width rows; num_cols above the line depth acts as the line depth.
    // One full row, then the start of the next row reads the line back.
    task automatic test_wide_rows();
        set_grid(2047, 2);
        send_grid(LINE_DEPTH, 1, 8192);
        send_grid(WIDE_TAIL, 1, 8192);
    endtask

    // Random grids of random shapes, mostly small, jitter plus noise.
    task automatic test_random_grids(input int target);
        int unsigned cols;
        int unsigned rows;
        while (accept_count < target)
        begin
            cols = $urandom_range(2, 12);
            rows = $urandom_range(2, 8);
            set_grid(cols, rows);
            send_grid(cols, rows, $signed($urandom_range(0, 40000)) - 20000);
        end
    endtask

    // Hold off the receiver for a long stretch while nodes keep coming.
    task automatic test_backpressure();
        set_grid(8, 6);
        long_hold = 1'b1;
        use_gaps = 1'b0;
        send_grid(8, 6, 2048);
        use_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on its own pattern; long hold when asked.
    // ------------------------------------------------------------------
    int hold_cycles;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cycles = 0;
        end
        else if (long_hold)
        begin
            out_ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= 3000)
            begin
                long_hold = 1'b0;
                hold_cycles = 0;
            end
        end
        else
            out_ready <= ($urandom_range(0, 99) < 70) || (accept_count[9:8] == 2'b01);
    end

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        metrics_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (metrics_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %p", dut_res);
            end
            else
            begin
                want = metrics_due.pop_front();
                if (want !== dut_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch beat %0d:\n  exp %p\n  got %p",
                                 results_seen, want, dut_res);
                end
            end
        end
    end

    // Count input beats and watch for a stuck block.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                accept_count++;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        node_x = '0;
        node_y = '0;
        mismatch_count = 0;
        accept_count = 0;
        results_seen = 0;
        quiet_cycles = 0;
        long_hold = 1'b0;
        use_gaps = 1'b1;
        burst_left = 0;
        ul_x = '0; ul_y = '0; left_x = '0; left_y = '0;
        row_pos = 0; col_pos = 0;
        cols_cfg = 1024; rows_cfg = 1024;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_min_grid();
        test_degenerate();
        test_backpressure();
        test_random_grids(1850 - LINE_DEPTH - WIDE_TAIL);
        test_wide_rows();

        drain_block();
        if (mismatch_count == 0 && metrics_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/sgm_pkg.sv
rtl/core/sgm_front.sv
rtl/core/sgm_fifo.sv
rtl/core/sgm_isqrt.sv
rtl/core/sgm_back.sv
rtl/core/structured_grid_metrics_2d_core.sv
rtl/core/sgm_checker.sv
verif/testbench.sv
